// ===== rtl/sao_pkg.sv =====
// Shared types, register codes and constants for the sprite alpha overlay.
package sao_pkg;

  localparam int CHAN_W = 8;
  localparam int NUM_CH = 3;
  localparam int CFG_W  = 12;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [NUM_CH-1:0] pix_t;

  // One stored sprite texel: alpha on top, then chan_c, chan_b, chan_a.
  typedef struct packed {
    chan_t alpha;
    pix_t  rgb;
  } texel_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_SPRITE_LEFT   = 3'd2,
    CFG_SPRITE_TOP    = 3'd3,
    CFG_SPRITE_WIDTH  = 3'd4,
    CFG_SPRITE_HEIGHT = 3'd5
  } cfg_idx_e;

  // Raw configuration register contents
  typedef struct packed {
    logic [11:0]        frame_width;
    logic [11:0]        frame_height;
    logic signed [11:0] sprite_left;
    logic signed [11:0] sprite_top;
    logic [6:0]         sprite_width;
    logic [6:0]         sprite_height;
  } cfg_regs_t;

  localparam logic [11:0] RST_FRAME_WIDTH   = 12'd640;
  localparam logic [11:0] RST_FRAME_HEIGHT  = 12'd480;
  localparam logic [11:0] RST_SPRITE_LEFT   = 12'd0;
  localparam logic [11:0] RST_SPRITE_TOP    = 12'd0;
  localparam logic [6:0]  RST_SPRITE_WIDTH  = 7'd64;
  localparam logic [6:0]  RST_SPRITE_HEIGHT = 7'd64;

  // Input item commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam chan_t ALPHA_MAX = 8'd255;

endpackage

// ===== rtl/sao_cfg_regs.sv =====
// Configuration register file of the sprite alpha overlay.
module sao_cfg_regs import sao_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [2:0]       idx_i,
  input  logic [CFG_W-1:0] wdata_i,
  output cfg_regs_t        regs_o
);

  cfg_regs_t regs_q;

  // Decode the write index and update one register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.frame_width   <= RST_FRAME_WIDTH;
      regs_q.frame_height  <= RST_FRAME_HEIGHT;
      regs_q.sprite_left   <= RST_SPRITE_LEFT;
      regs_q.sprite_top    <= RST_SPRITE_TOP;
      regs_q.sprite_width  <= RST_SPRITE_WIDTH;
      regs_q.sprite_height <= RST_SPRITE_HEIGHT;
    end else if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_FRAME_WIDTH:   regs_q.frame_width   <= wdata_i;
        CFG_FRAME_HEIGHT:  regs_q.frame_height  <= wdata_i;
        CFG_SPRITE_LEFT:   regs_q.sprite_left   <= wdata_i;
        CFG_SPRITE_TOP:    regs_q.sprite_top    <= wdata_i;
        CFG_SPRITE_WIDTH:  regs_q.sprite_width  <= wdata_i[6:0];
        CFG_SPRITE_HEIGHT: regs_q.sprite_height <= wdata_i[6:0];
        default: ;
      endcase
    end
  end

  assign regs_o = regs_q;

endmodule

// ===== rtl/sao_sprite_store.sv =====
// Sprite texel memory: one write port, one registered read port.
module sao_sprite_store import sao_pkg::*; #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  texel_t            wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output texel_t            rdata_o
);

  texel_t mem [DEPTH];
  texel_t rdata_q;

  // Write a loaded texel
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read and hold the texel for the pixel in flight
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sao_blend.sv =====
// Per-channel alpha blend of a sprite texel over a background pixel.
module sao_blend import sao_pkg::*; #(
  parameter int COLOR_CHANNELS = 3
) (
  input  pix_t   bg_i,
  input  texel_t texel_i,
  input  logic   hit_i,
  output pix_t   pix_o,
  output logic   covered_o
);

  logic opaque;

  assign opaque    = hit_i && (texel_i.alpha != '0);
  assign covered_o = opaque;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
    if (c < COLOR_CHANNELS) begin : g_mix
      logic [15:0] mix;
      logic [16:0] quo;

      // Weighted sum, then divide by 255 as (v + 1 + v/256) / 256
      assign mix = 16'(bg_i[c]) * 16'(ALPHA_MAX - texel_i.alpha)
                 + 16'(texel_i.rgb[c]) * 16'(texel_i.alpha);
      assign quo = 17'(mix) + 17'(mix[15:8]) + 17'd1;
      assign pix_o[c] = opaque ? quo[15:8] : bg_i[c];
    end else begin : g_pass
      assign pix_o[c] = bg_i[c];
    end
  end

endmodule

// ===== rtl/sprite_alpha_overlay.sv =====
// Top level of the sprite alpha overlay: counters, sprite lookup and pipeline.
//
// Usage: configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i
// while the block is idle. Input items arrive on in_valid_i / in_stall_o; an
// item with cmd_i low stores the next sprite texel in raster order and gives
// no result, an item with cmd_i high is one background pixel in raster order.
// Each pixel gives one result on out_valid_o / out_stall_i, in input order.
// Throughput is one item per cycle while in_stall_o is low. A pixel's transfer
// captures the sprite memory read beside the pixel in the first stage; the
// output register then captures the blend, and the result transfers out there.
// When the receiver stalls, the output register holds its result and the
// stage behind it still takes one more pixel; input stalls only when both
// are full and the output is stalled.
// Reset restores the register defaults, clears the load pointer and the
// column and row counters, and empties the pipeline. The sprite memory is
// not cleared: load the sprite before the first pixel it covers.
module sprite_alpha_overlay import sao_pkg::*; #(
  parameter int SPRITE_MAX_W   = 64,
  parameter int SPRITE_MAX_H   = 64,
  parameter int FRAME_MAX_DIM  = 2048,
  parameter int COLOR_CHANNELS = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic [7:0]       chan_a_i,
  input  logic [7:0]       chan_b_i,
  input  logic [7:0]       chan_c_i,
  input  logic [7:0]       alpha_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_a_o,
  output logic [7:0]       out_b_o,
  output logic [7:0]       out_c_o,
  output logic             covered_o,
  output logic             frame_end_o
);

  localparam int STORE_DEPTH = SPRITE_MAX_W * SPRITE_MAX_H;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int AREA_W = $clog2(STORE_DEPTH + 1);
  localparam int SW_W   = $clog2(SPRITE_MAX_W + 1);
  localparam int SH_W   = $clog2(SPRITE_MAX_H + 1);
  localparam int DIM_W  = $clog2(FRAME_MAX_DIM + 1);
  localparam int CNT_W  = $clog2(FRAME_MAX_DIM);
  localparam int POS_W  = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 2;

  cfg_regs_t regs;

  logic [SW_W-1:0]   sw;
  logic [SH_W-1:0]   sh;
  logic [DIM_W-1:0]  fw;
  logic [DIM_W-1:0]  fh;
  logic [AREA_W-1:0] area_raw;
  logic [AREA_W-1:0] area;

  logic [CNT_W-1:0]  col_q, col_d;
  logic [CNT_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] lp_q, lp_d;
  logic [CNT_W-1:0]  x, y;
  logic              last_col, last_row;

  logic signed [POS_W-1:0] fx, fy;
  logic              hit;
  logic [SW_W-1:0]   fx_t;
  logic [SH_W-1:0]   fy_t;
  logic [AREA_W-1:0] addr_full;
  logic [ADDR_W-1:0] lp_cur;
  logic [AREA_W-1:0] lp_next;

  logic   in_acc, load_acc, pix_acc;
  logic   s1_adv, out_adv;
  logic   s1_valid_q, out_valid_q;
  pix_t   s1_bg_q;
  logic   s1_hit_q, s1_end_q;
  texel_t texel_wr, texel_rd;
  pix_t   pix_in, blend_pix;
  logic   blend_cov;
  pix_t   out_pix_q;
  logic   out_cov_q, out_end_q;

  sao_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .regs_o  (regs)
  );

  // Saturate the sprite and frame sizes; a zero frame size or sprite area counts as one
  always_comb begin
    sw = (32'(regs.sprite_width) > SPRITE_MAX_W) ? SW_W'(SPRITE_MAX_W)
                                                 : SW_W'(regs.sprite_width);
    sh = (32'(regs.sprite_height) > SPRITE_MAX_H) ? SH_W'(SPRITE_MAX_H)
                                                  : SH_W'(regs.sprite_height);
    if (regs.frame_width == '0) begin
      fw = DIM_W'(1);
    end else if (32'(regs.frame_width) > FRAME_MAX_DIM) begin
      fw = DIM_W'(FRAME_MAX_DIM);
    end else begin
      fw = DIM_W'(regs.frame_width);
    end
    if (regs.frame_height == '0) begin
      fh = DIM_W'(1);
    end else if (32'(regs.frame_height) > FRAME_MAX_DIM) begin
      fh = DIM_W'(FRAME_MAX_DIM);
    end else begin
      fh = DIM_W'(regs.frame_height);
    end
    area_raw = AREA_W'(sw) * AREA_W'(sh);
    area     = (area_raw == '0) ? AREA_W'(1) : area_raw;
  end

  // Handshake: the first stage loads when empty or when it moves on
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_acc   = in_acc && (cmd_i == CMD_LOAD);
  assign pix_acc    = in_acc && (cmd_i == CMD_PIXEL);

  // Locate the pixel in the frame and in the sprite
  always_comb begin
    x = (DIM_W'(col_q) >= fw) ? '0 : col_q;
    y = (DIM_W'(row_q) >= fh) ? '0 : row_q;
    last_col = (DIM_W'(x) == (fw - DIM_W'(1)));
    last_row = (DIM_W'(y) == (fh - DIM_W'(1)));

    fx = $signed(POS_W'(x)) - POS_W'($signed(regs.sprite_left));
    fy = $signed(POS_W'(y)) - POS_W'($signed(regs.sprite_top));
    hit = !fx[POS_W-1] && !fy[POS_W-1]
       && (fx < $signed(POS_W'(sw))) && (fy < $signed(POS_W'(sh)));
    fx_t = fx[SW_W-1:0];
    fy_t = fy[SH_W-1:0];
    addr_full = AREA_W'(fy_t) * AREA_W'(sw) + AREA_W'(fx_t);

    col_d = col_q;
    row_d = row_q;
    if (pix_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : y + CNT_W'(1);
      end else begin
        col_d = x + CNT_W'(1);
        row_d = y;
      end
    end
  end

  // Advance the load pointer, wrapping at the sprite area
  always_comb begin
    lp_cur  = (AREA_W'(lp_q) >= area) ? '0 : lp_q;
    lp_next = AREA_W'(lp_cur) + AREA_W'(1);
    lp_d    = lp_q;
    if (load_acc) begin
      lp_d = (lp_next >= area) ? '0 : ADDR_W'(lp_next);
    end
  end

  assign texel_wr = '{alpha: alpha_i, rgb: {chan_c_i, chan_b_i, chan_a_i}};

  sao_sprite_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (lp_cur),
    .wdata_i (texel_wr),
    .re_i    (pix_acc),
    .raddr_i (ADDR_W'(addr_full)),
    .rdata_o (texel_rd)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      lp_q        <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      lp_q  <= lp_d;
      if (s1_adv) begin
        s1_valid_q <= pix_acc;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Hold the pixel beside its texel read
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_bg_q  <= {chan_c_i, chan_b_i, chan_a_i};
      s1_hit_q <= hit;
      s1_end_q <= last_col && last_row;
    end
  end

  assign pix_in = s1_bg_q;

  sao_blend #(
    .COLOR_CHANNELS (COLOR_CHANNELS)
  ) u_blend (
    .bg_i      (pix_in),
    .texel_i   (texel_rd),
    .hit_i     (s1_hit_q),
    .pix_o     (blend_pix),
    .covered_o (blend_cov)
  );

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_pix_q <= blend_pix;
      out_cov_q <= blend_cov;
      out_end_q <= s1_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_a_o     = out_pix_q[0];
  assign out_b_o     = out_pix_q[1];
  assign out_c_o     = out_pix_q[2];
  assign covered_o   = out_cov_q;
  assign frame_end_o = out_end_q;

  // A pixel outside the sprite is never reported as covered
  a_no_cover_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_hit_q && out_adv) |=> !covered_o)
    else $error("covered set for a pixel outside the sprite");

  // A pixel in the first stage reaches the output when it can move
  a_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_adv) |=> out_valid_o)
    else $error("pixel lost between first stage and output");

  // Input stalls when both stages are full and the output is stalled
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while the pipeline is full");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the sprite alpha overlay: directed and random pixel streams.
module testbench;
  import sao_pkg::*;

  localparam int SPRITE_MAX_W     = 64;
  localparam int SPRITE_MAX_H     = 64;
  localparam int FRAME_MAX_DIM    = 2048;
  localparam int STORE_DEPTH      = SPRITE_MAX_W * SPRITE_MAX_H;
  localparam int OPAQUE           = int'(ALPHA_MAX);
  localparam int REST_CYCLES      = 4;
  localparam int PIXELS_PER_MODE  = 600;
  localparam int DRAIN_LIMIT      = 20000;

  typedef struct packed {
    chan_t out_a;
    chan_t out_b;
    chan_t out_c;
    logic  covered;
    logic  frame_end;
  } blended_pixel_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [2:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             cmd_i;
  logic [7:0]       chan_a_i;
  logic [7:0]       chan_b_i;
  logic [7:0]       chan_c_i;
  logic [7:0]       alpha_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [7:0]       out_a_o;
  logic [7:0]       out_b_o;
  logic [7:0]       out_c_o;
  logic             covered_o;
  logic             frame_end_o;

  // Shadow copy of the overlay state
  cfg_regs_t      regs;
  texel_t         sprite_texels [STORE_DEPTH];
  bit             texel_loaded [STORE_DEPTH];
  int             load_ptr;
  int             col_cnt;
  int             row_cnt;
  blended_pixel_t blended_q [$];

  int send_idle_pct  = 17;
  int recv_idle_pct  = 69;
  int hold_left      = 0;
  int mismatch_count = 0;

  sprite_alpha_overlay DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .chan_a_i    (chan_a_i),
    .chan_b_i    (chan_b_i),
    .chan_c_i    (chan_c_i),
    .alpha_i     (alpha_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_a_o     (out_a_o),
    .out_b_o     (out_b_o),
    .out_c_o     (out_c_o),
    .covered_o   (covered_o),
    .frame_end_o (frame_end_o)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  // Drive the receiver stall: long hold-offs first, otherwise random
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic int eff_size(int v, int hi);
    return (v > hi) ? hi : v;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each output transfer with the oldest predicted pixel
  always @(posedge clk_i) begin : check_results
    blended_pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (blended_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0d %0d %0d covered %0b end %0b",
                 $time, out_a_o, out_b_o, out_c_o, covered_o, frame_end_o);
        mismatch_count++;
      end else begin
        want = blended_q.pop_front();
        check_field("out_a", want.out_a, out_a_o);
        check_field("out_b", want.out_b, out_b_o);
        check_field("out_c", want.out_c, out_c_o);
        check_field("covered", 8'(want.covered), 8'(covered_o));
        check_field("frame_end", 8'(want.frame_end), 8'(frame_end_o));
      end
    end
  end

  // Advance the shadow state by one accepted item and queue its pixel
  task automatic apply_overlay_item(input logic cmd, input chan_t ca, input chan_t cb,
                                    input chan_t cc, input chan_t al);
    int             sw;
    int             sh;
    int             fw;
    int             fh;
    int             area;
    int             x;
    int             y;
    int             fx;
    int             fy;
    int             a;
    int             bg [NUM_CH];
    texel_t         tx;
    blended_pixel_t px;
    sw = eff_size(int'(regs.sprite_width), SPRITE_MAX_W);
    sh = eff_size(int'(regs.sprite_height), SPRITE_MAX_H);
    fw = (regs.frame_width == 0) ? 1 : eff_size(int'(regs.frame_width), FRAME_MAX_DIM);
    fh = (regs.frame_height == 0) ? 1 : eff_size(int'(regs.frame_height), FRAME_MAX_DIM);
    if (cmd == CMD_LOAD) begin
      // Store the texel and wrap the pointer within the sprite area
      area = (sw * sh == 0) ? 1 : sw * sh;
      if (load_ptr >= area) load_ptr = 0;
      sprite_texels[load_ptr] = {al, cc, cb, ca};
      texel_loaded[load_ptr] = 1'b1;
      load_ptr++;
      if (load_ptr >= area) load_ptr = 0;
    end else begin
      // Wrap counters left beyond a shrunken frame
      if (col_cnt >= fw) col_cnt = 0;
      if (row_cnt >= fh) row_cnt = 0;
      x = col_cnt;
      y = row_cnt;
      bg[0] = int'(ca);
      bg[1] = int'(cb);
      bg[2] = int'(cc);
      px.covered = 1'b0;
      fx = x - int'($signed(regs.sprite_left));
      fy = y - int'($signed(regs.sprite_top));
      if (fx >= 0 && fy >= 0 && fx < sw && fy < sh) begin
        tx = sprite_texels[fy * sw + fx];
        a = int'(tx.alpha);
        if (a != 0) begin
          px.covered = 1'b1;
          for (int c = 0; c < NUM_CH; c++) begin
            bg[c] = (bg[c] * (OPAQUE - a) + int'(tx.rgb[c]) * a) / OPAQUE;
          end
        end
      end
      px.out_a = 8'(bg[0]);
      px.out_b = 8'(bg[1]);
      px.out_c = 8'(bg[2]);
      px.frame_end = (x == fw - 1) && (y == fh - 1);
      col_cnt = x + 1;
      if (col_cnt >= fw) begin
        col_cnt = 0;
        row_cnt = y + 1;
        if (row_cnt >= fh) row_cnt = 0;
      end
      blended_q = {blended_q, px};
    end
  endtask

  // Offer one item after a random gap and hold it until the transfer
  task automatic offer_item(input logic cmd, input chan_t ca, input chan_t cb,
                            input chan_t cc, input chan_t al);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    chan_a_i   <= ca;
    chan_b_i   <= cb;
    chan_c_i   <= cc;
    alpha_i    <= al;
    do @(posedge clk_i); while (in_stall_o == 1'b1);
    apply_overlay_item(cmd, ca, cb, cc, al);
  endtask

  task automatic offer_texel();
    chan_t al;
    case ($urandom_range(3))
      0:       al = 8'd0;
      1:       al = ALPHA_MAX;
      default: al = 8'($urandom_range(255));
    endcase
    offer_item(CMD_LOAD, 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)), al);
  endtask

  task automatic offer_pixel();
    offer_item(CMD_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // Stop offering until every pixel is back, then let the pipeline settle
  task automatic drain_and_rest();
    in_valid_i <= 1'b0;
    while (blended_q.size() != 0) @(posedge clk_i);
    repeat (REST_CYCLES) @(posedge clk_i);
  endtask

  // Write all registers, with junk above the narrow sprite size fields
  task automatic program_overlay(input cfg_regs_t c);
    cfg_idx_e         idx;
    logic [CFG_W-1:0] data;
    logic [4:0]       spare_bits;
    cfg_we_i <= 1'b1;
    idx = idx.first();
    repeat (idx.num()) begin
      spare_bits = 5'($urandom_range(31));
      case (idx)
        CFG_FRAME_WIDTH:  data = c.frame_width;
        CFG_FRAME_HEIGHT: data = c.frame_height;
        CFG_SPRITE_LEFT:  data = c.sprite_left;
        CFG_SPRITE_TOP:   data = c.sprite_top;
        CFG_SPRITE_WIDTH: data = {spare_bits, c.sprite_width};
        default:          data = {spare_bits, c.sprite_height};
      endcase
      cfg_idx_i   <= idx;
      cfg_wdata_i <= data;
      @(posedge clk_i);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
    regs = c;
  endtask

  // Load the whole sprite area unless every texel in it was written already
  task automatic fill_sprite_area();
    int area;
    bit missing;
    area = eff_size(int'(regs.sprite_width), SPRITE_MAX_W)
         * eff_size(int'(regs.sprite_height), SPRITE_MAX_H);
    if (area == 0) area = 1;
    missing = 1'b0;
    for (int i = 0; i < area; i++) begin
      if (!texel_loaded[i]) missing = 1'b1;
    end
    if (missing) repeat (area) offer_texel();
  endtask

  // Opaque, transparent and half alpha texels over extreme backgrounds
  task automatic test_basic_blend();
    program_overlay('{12'd4, 12'd2, 12'sd1, 12'sd0, 7'd3, 7'd1});
    offer_item(CMD_LOAD, 8'd255, 8'd0, 8'd128, ALPHA_MAX);
    offer_item(CMD_LOAD, 8'd17, 8'd34, 8'd51, 8'd0);
    offer_item(CMD_LOAD, 8'd0, 8'd255, 8'd200, 8'd128);
    // row 0 columns 1..3 lie under the sprite, row 1 passes through
    offer_item(CMD_PIXEL, 8'd0, 8'd255, 8'd0, 8'd255);
    offer_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0);
    offer_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255, 8'd0);
    offer_item(CMD_PIXEL, 8'd255, 8'd0, 8'd0, 8'd255);
    offer_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255);
    offer_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0);
    offer_item(CMD_PIXEL, 8'd128, 8'd64, 8'd32, 8'd1);
    offer_item(CMD_PIXEL, 8'd1, 8'd2, 8'd3, 8'd254);
  endtask

  // Sprite clipped at the top left, then at the bottom right
  task automatic test_clipping();
    drain_and_rest();
    program_overlay('{12'd2, 12'd2, -12'sd1, -12'sd1, 7'd2, 7'd2});
    offer_item(CMD_LOAD, 8'd255, 8'd255, 8'd255, 8'd1);
    offer_item(CMD_LOAD, 8'd0, 8'd0, 8'd0, 8'd255);
    offer_item(CMD_LOAD, 8'd10, 8'd20, 8'd30, 8'd200);
    offer_item(CMD_LOAD, 8'd200, 8'd100, 8'd50, 8'd254);
    repeat (4) offer_item(CMD_PIXEL, 8'd0, 8'd128, 8'd255, 8'd0);
    drain_and_rest();
    program_overlay('{12'd2, 12'd2, 12'sd1, 12'sd1, 7'd2, 7'd2});
    repeat (4) offer_item(CMD_PIXEL, 8'd255, 8'd0, 8'd127, 8'd255);
  endtask

  // Hold the output for a long stretch while pixels keep coming
  task automatic test_backpressure();
    hold_left = 200;
    repeat (40) offer_pixel();
    drain_and_rest();
  endtask

  // Random settings with random pixel and texel streams under each idle mode
  task automatic test_random_phases();
    cfg_regs_t c;
    int        phase;
    int        sent;
    int        n;
    phase = 0;
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 69 : 0;
      recv_idle_pct = (mode == 0) ? 69 : (mode == 1) ? 17 : 0;
      sent = 0;
      while (sent < PIXELS_PER_MODE) begin
        c.frame_width   = 12'($urandom_range(1, 20));
        c.frame_height  = 12'($urandom_range(1, 12));
        c.sprite_left   = 12'(int'($urandom_range(0, 30)) - 8);
        c.sprite_top    = 12'(int'($urandom_range(0, 20)) - 8);
        c.sprite_width  = 7'($urandom_range(0, 9));
        c.sprite_height = 7'($urandom_range(0, 9));
        // Force the extremes in the first phases
        case (phase)
          0: c = '{12'd2048, 12'd2048, 12'sd0, 12'sd0, 7'd64, 7'd1};
          1: c = '{12'd1, 12'd1, 12'sd0, 12'sd0, 7'd1, 7'd1};
          2: c = '{12'd0, 12'hFFF, 12'h800, 12'h7FF, 7'd0, 7'd127};
          3: c = '{12'hFFF, 12'd0, 12'h7FF, 12'h800, 7'd127, 7'd0};
          4: begin
            c.frame_width   = 12'd10;
            c.frame_height  = 12'd10;
            c.sprite_left   = -12'sd60;
            c.sprite_top    = 12'sd0;
            c.sprite_width  = 7'd65;
            c.sprite_height = 7'd2;
          end
          default: ;
        endcase
        drain_and_rest();
        program_overlay(c);
        fill_sprite_area();
        n = $urandom_range(40, 160);
        repeat (n) begin
          if ($urandom_range(99) < 85) offer_pixel();
          else offer_texel();
        end
        sent += n;
        phase++;
      end
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_FRAME_WIDTH;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    cmd_i       <= CMD_LOAD;
    chan_a_i    <= '0;
    chan_b_i    <= '0;
    chan_c_i    <= '0;
    alpha_i     <= '0;
    regs = '{RST_FRAME_WIDTH, RST_FRAME_HEIGHT, RST_SPRITE_LEFT, RST_SPRITE_TOP,
             RST_SPRITE_WIDTH, RST_SPRITE_HEIGHT};
    load_ptr = 0;
    col_cnt  = 0;
    row_cnt  = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_blend();
    test_clipping();
    test_backpressure();
    test_random_phases();

    // Wait out the last pixels, bounded
    in_valid_i <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && blended_q.size() != 0; i++) @(posedge clk_i);
    repeat (2 * REST_CYCLES) @(posedge clk_i);
    if (blended_q.size() != 0) begin
      $display("%0t missing results: expected %0d more, actual none", $time, blended_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
